/* rtl/core/vsaq_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// vsaq_pkg: shared types and constants
// Sample and alert payloads, register map, event codes and reset values.
// ----------------------------------------------------------------------------
package vsaq_pkg;

	localparam int unsigned RunW    = 8;
	localparam int unsigned SeqW    = 32;
	localparam int unsigned TimeW   = 32;
	localparam int unsigned ReasonW = 5;
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDataW = 56;

	localparam logic [RunW-1:0] RunMax = 8'd255;

	localparam int unsigned RsnHrLow   = 0;
	localparam int unsigned RsnHrHigh  = 1;
	localparam int unsigned RsnSpo2Low = 2;
	localparam int unsigned RsnTempLow = 3;
	localparam int unsigned RsnTempHigh = 4;

	localparam logic [15:0]         RstHrWarnLimits  = 16'd30770;
	localparam logic [6:0]          RstSpo2WarnLow   = 7'd90;
	localparam logic signed [15:0]  RstTempWarnLow   = 16'sd350;
	localparam logic signed [15:0]  RstTempWarnHigh  = 16'sd380;
	localparam logic [55:0]         RstCriticalLimits = 56'd434312802833960;
	localparam logic [RunW-1:0]     RstConfirmCount  = 8'd3;
	localparam logic [RunW-1:0]     RstClearCount    = 8'd3;
	localparam logic [TimeW-1:0]    RstRepeatMs      = 32'd30000;
	localparam logic [SeqW-1:0]     RstNextSeq       = 32'd1;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_HR_WARN     = 3'd0,
		CFG_SPO2_WARN   = 3'd1,
		CFG_TEMP_LOW    = 3'd2,
		CFG_TEMP_HIGH   = 3'd3,
		CFG_CRITICAL    = 3'd4,
		CFG_CONFIRM     = 3'd5,
		CFG_CLEAR       = 3'd6,
		CFG_REPEAT      = 3'd7
	} cfg_idx_t;

	typedef enum logic [1:0] {
		KIND_TRIGGERED = 2'd0,
		KIND_REMINDER  = 2'd1,
		KIND_RECOVERED = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		SEV_NORMAL   = 2'd0,
		SEV_WARNING  = 2'd1,
		SEV_CRITICAL = 2'd2
	} sev_t;

	typedef struct packed {
		logic [7:0]         pulse_bpm;
		logic [6:0]         oxygen_saturation;
		logic signed [15:0] temperature;
		logic [TimeW-1:0]   timestamp_ms;
	} sample_t;

	typedef struct packed {
		kind_t              event_kind;
		sev_t               severity;
		logic [ReasonW-1:0] reason_mask;
		logic [SeqW-1:0]    sequence_number;
		logic [TimeW-1:0]   event_time_ms;
		logic [7:0]         event_pulse_bpm;
		logic [6:0]         event_oxygen;
		logic signed [15:0] event_temperature;
	} alert_t;

	typedef struct packed {
		logic [15:0]        hr_warn_limits;
		logic [6:0]         spo2_warn_low;
		logic signed [15:0] temp_warn_low;
		logic signed [15:0] temp_warn_high;
		logic [55:0]        critical_limits;
		logic [RunW-1:0]    confirm_count;
		logic [RunW-1:0]    clear_count;
		logic [TimeW-1:0]   repeat_interval_ms;
	} cfg_t;

	typedef struct packed {
		logic            fire;
		kind_t           kind;
		logic [SeqW-1:0] seq;
	} decision_t;

endpackage
`default_nettype wire

/* rtl/core/vsaq_cfg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// vsaq_cfg: configuration register file
// Holds the limits, run counts and reminder interval; always ready.
// ----------------------------------------------------------------------------
module vsaq_cfg (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [vsaq_pkg::CfgIdxW-1:0] cfg_index,
	input  wire logic [vsaq_pkg::CfgDataW-1:0] cfg_data,
	output vsaq_pkg::cfg_t                    cfg
);
	import vsaq_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hr_warn_limits     <= RstHrWarnLimits;
			cfg_q.spo2_warn_low      <= RstSpo2WarnLow;
			cfg_q.temp_warn_low      <= RstTempWarnLow;
			cfg_q.temp_warn_high     <= RstTempWarnHigh;
			cfg_q.critical_limits    <= RstCriticalLimits;
			cfg_q.confirm_count      <= RstConfirmCount;
			cfg_q.clear_count        <= RstClearCount;
			cfg_q.repeat_interval_ms <= RstRepeatMs;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_HR_WARN:   cfg_q.hr_warn_limits     <= cfg_data[15:0];
				CFG_SPO2_WARN: cfg_q.spo2_warn_low      <= cfg_data[6:0];
				CFG_TEMP_LOW:  cfg_q.temp_warn_low      <= $signed(cfg_data[15:0]);
				CFG_TEMP_HIGH: cfg_q.temp_warn_high     <= $signed(cfg_data[15:0]);
				CFG_CRITICAL:  cfg_q.critical_limits    <= cfg_data[55:0];
				CFG_CONFIRM:   cfg_q.confirm_count      <= cfg_data[RunW-1:0];
				CFG_CLEAR:     cfg_q.clear_count        <= cfg_data[RunW-1:0];
				CFG_REPEAT:    cfg_q.repeat_interval_ms <= cfg_data[TimeW-1:0];
			endcase
		end
	end

endmodule
`default_nettype wire

/* rtl/core/vsaq_classify.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// vsaq_classify: limit checks
// Builds the reason mask from the warning limits and the severity from
// the critical limits for one sample; it is normal when no reason is set.
// ----------------------------------------------------------------------------
module vsaq_classify (
	input  wire vsaq_pkg::sample_t             sample,
	input  wire vsaq_pkg::cfg_t                cfg,
	output logic [vsaq_pkg::ReasonW-1:0]       reasons,
	output vsaq_pkg::sev_t                     severity
);
	import vsaq_pkg::*;

	logic [7:0]         hr_crit_low;
	logic [7:0]         hr_crit_high;
	logic [7:0]         spo2_crit_low;
	logic signed [15:0] temp_crit_low;
	logic signed [15:0] temp_crit_high;
	logic               critical;

	assign hr_crit_low    = cfg.critical_limits[7:0];
	assign hr_crit_high   = cfg.critical_limits[15:8];
	assign spo2_crit_low  = cfg.critical_limits[23:16];
	assign temp_crit_low  = $signed(cfg.critical_limits[39:24]);
	assign temp_crit_high = $signed(cfg.critical_limits[55:40]);

	always_comb begin
		reasons = '0;
		if (sample.pulse_bpm < cfg.hr_warn_limits[7:0]) begin
			reasons[RsnHrLow] = 1'b1;
		end else if (sample.pulse_bpm > cfg.hr_warn_limits[15:8]) begin
			reasons[RsnHrHigh] = 1'b1;
		end
		reasons[RsnSpo2Low] = sample.oxygen_saturation < cfg.spo2_warn_low;
		if (sample.temperature < cfg.temp_warn_low) begin
			reasons[RsnTempLow] = 1'b1;
		end else if (sample.temperature >= cfg.temp_warn_high) begin
			reasons[RsnTempHigh] = 1'b1;
		end
	end

	assign critical = (sample.pulse_bpm < hr_crit_low)
		|| (sample.pulse_bpm > hr_crit_high)
		|| ({1'b0, sample.oxygen_saturation} < spo2_crit_low)
		|| (sample.temperature < temp_crit_low)
		|| (sample.temperature >= temp_crit_high);

	always_comb begin
		priority if (reasons == '0) begin
			severity = SEV_NORMAL;
		end else if (critical) begin
			severity = SEV_CRITICAL;
		end else begin
			severity = SEV_WARNING;
		end
	end

endmodule
`default_nettype wire

/* rtl/core/vsaq_tracker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// vsaq_tracker: alarm state
// Run counters, alarm flag, sequence number and last event time; decides
// whether the sample in stage one raises an event.
// ----------------------------------------------------------------------------
module vsaq_tracker (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire vsaq_pkg::cfg_t              cfg,
	input  wire logic                        advance,
	input  wire logic                        abnormal,
	input  wire logic [vsaq_pkg::TimeW-1:0]  now,
	output vsaq_pkg::decision_t              dec
);
	import vsaq_pkg::*;

	logic              active_q;
	logic [RunW-1:0]   abnormal_run_q;
	logic [RunW-1:0]   normal_run_q;
	logic [SeqW-1:0]   next_seq_q;
	logic [TimeW-1:0]  last_time_q;

	logic [RunW-1:0]   abnormal_run_d;
	logic [RunW-1:0]   normal_run_d;
	logic [TimeW-1:0]  elapsed;
	logic              trig;
	logic              remind;
	logic              recov;

	always_comb begin
		abnormal_run_d = '0;
		normal_run_d   = '0;
		if (abnormal) begin
			abnormal_run_d = (abnormal_run_q == RunMax) ? RunMax : abnormal_run_q + 1'b1;
		end else begin
			normal_run_d = (normal_run_q == RunMax) ? RunMax : normal_run_q + 1'b1;
		end
	end

	assign elapsed = now - last_time_q;
	assign trig    = abnormal && !active_q && (abnormal_run_d >= cfg.confirm_count);
	assign remind  = abnormal && active_q && (elapsed >= cfg.repeat_interval_ms);
	assign recov   = !abnormal && active_q && (normal_run_d >= cfg.clear_count);

	always_comb begin
		dec.fire = trig || remind || recov;
		dec.seq  = next_seq_q;
		priority if (trig) begin
			dec.kind = KIND_TRIGGERED;
		end else if (remind) begin
			dec.kind = KIND_REMINDER;
		end else begin
			dec.kind = KIND_RECOVERED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q       <= 1'b0;
			abnormal_run_q <= '0;
			normal_run_q   <= '0;
			next_seq_q     <= RstNextSeq;
			last_time_q    <= '0;
		end else if (advance) begin
			abnormal_run_q <= abnormal_run_d;
			normal_run_q   <= normal_run_d;
			if (trig) begin
				active_q <= 1'b1;
			end else if (recov) begin
				active_q <= 1'b0;
			end
			if (dec.fire) begin
				next_seq_q  <= next_seq_q + 1'b1;
				last_time_q <= now;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_seq_step: assert property (@(posedge clk) disable iff (!arst_n)
		advance && dec.fire |=> next_seq_q == $past(next_seq_q) + 1'b1)
		else $error("sequence number did not advance on event");

	a_active_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(active_q) |-> $past(advance && trig))
		else $error("alarm raised without trigger");

	a_runs_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(abnormal_run_q != '0 && normal_run_q != '0))
		else $error("abnormal and normal runs both nonzero");
`endif

endmodule
`default_nettype wire

/* rtl/core/vital_sign_alarm_qualifier.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// vital_sign_alarm_qualifier: vitals alarm qualification
// Checks each vitals sample against warning and critical limits, tracks
// abnormal and normal runs, and raises triggered, reminder and recovered
// alerts with a running sequence number.
//
//   channel  signals                            dir  transfer
//   sample   sample_valid/sample_stall/sample   in   valid && !stall
//   alert    alert_valid/alert_stall/alert      out  valid && !stall
//   cfg      cfg_valid/cfg_ready/cfg_index/data in   valid && ready
//
// One sample per cycle sustained unless a stalled alert holds stage one.
// Stage one holds the sample; limit checks and the alarm update sit between
// it and the alert register, and the alarm state moves as the sample leaves.
// Reset clears the alarm state, the run counters and all valid flags.
// A stalled alert holds stage one once it is full, and with it the sample
// input, whether or not the held sample raises an alert.
// ----------------------------------------------------------------------------
module vital_sign_alarm_qualifier (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          sample_valid,
	output logic                               sample_stall,
	input  wire vsaq_pkg::sample_t             sample,
	output logic                               alert_valid,
	input  wire logic                          alert_stall,
	output vsaq_pkg::alert_t                   alert,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [vsaq_pkg::CfgIdxW-1:0]  cfg_index,
	input  wire logic [vsaq_pkg::CfgDataW-1:0] cfg_data
);
	import vsaq_pkg::*;

	cfg_t               cfg;
	logic               valid_s1;
	sample_t            sample_s1;
	logic [ReasonW-1:0] reasons;
	sev_t               severity;
	decision_t          dec;
	logic               out_free;
	logic               advance;
	logic               alert_valid_q;
	alert_t             alert_q;

	vsaq_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	vsaq_classify u_classify (
		.sample   (sample_s1),
		.cfg      (cfg),
		.reasons  (reasons),
		.severity (severity)
	);

	vsaq_tracker u_tracker (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.advance  (advance),
		.abnormal (reasons != '0),
		.now      (sample_s1.timestamp_ms),
		.dec      (dec)
	);

	assign out_free     = !alert_valid_q || !alert_stall;
	assign advance      = valid_s1 && out_free;
	assign sample_stall = valid_s1 && !out_free;
	assign alert_valid  = alert_valid_q;
	assign alert        = alert_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!sample_stall) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && !sample_stall) begin
			sample_s1 <= sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alert_valid_q <= 1'b0;
		end else if (out_free) begin
			alert_valid_q <= advance && dec.fire;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && dec.fire) begin
			alert_q.event_kind        <= dec.kind;
			alert_q.severity          <= severity;
			alert_q.reason_mask       <= reasons;
			alert_q.sequence_number   <= dec.seq;
			alert_q.event_time_ms     <= sample_s1.timestamp_ms;
			alert_q.event_pulse_bpm   <= sample_s1.pulse_bpm;
			alert_q.event_oxygen      <= sample_s1.oxygen_saturation;
			alert_q.event_temperature <= sample_s1.temperature;
		end
	end

`ifndef NO_ASSERTIONS
	a_stall_needs_s1: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> valid_s1)
		else $error("stall with empty stage one");

	a_recovered_normal: assert property (@(posedge clk) disable iff (!arst_n)
		alert_valid && alert.event_kind == KIND_RECOVERED
		|-> alert.severity == SEV_NORMAL && alert.reason_mask == '0)
		else $error("recovered alert not normal");

	a_alert_from_s1: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(alert_valid) |-> $past(valid_s1))
		else $error("alert without a sample in stage one");
`endif

endmodule
`default_nettype wire

/* sim/vital_sign_alarm_qualifier_tb.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// vital_sign_alarm_qualifier_tb: self-checking bench for the alarm qualifier
// A typed table of samples runs first against the reset limits, then several
// register settings follow (crossed limits, zero counts, all-zero, all-ones,
// random). Each accepted sample goes through a local alarm predictor. Every
// alert is checked field by field against the oldest expected alert. Both
// channels idle in random bursts, and one long alert hold-off fills the pipe.
// ----------------------------------------------------------------------------
module vital_sign_alarm_qualifier_tb;
	import vsaq_pkg::*;

	localparam int unsigned DrainCycles = 6;
	localparam int unsigned LongHold    = 300;

	typedef enum logic [1:0] {
		ROW_PREDICT,
		ROW_QUIET,
		ROW_ALERT
	} row_mode_t;

	typedef struct packed {
		sample_t   s;
		row_mode_t how;
		alert_t    want;
	} plan_row_t;

	localparam plan_row_t Plan [20] = '{
		'{'{8'd80,  7'd98,  16'sd370,   32'd100},   ROW_QUIET, '0},
		'{'{8'd0,   7'd0,   16'sh8000,  32'd200},   ROW_QUIET, '0},
		'{'{8'd255, 7'd127, 16'sh7FFF,  32'd300},   ROW_QUIET, '0},
		'{'{8'd130, 7'd95,  16'sd370,   32'd1000},  ROW_ALERT,
			'{KIND_TRIGGERED, SEV_WARNING, 5'd2, 32'd1, 32'd1000, 8'd130, 7'd95, 16'sd370}},
		'{'{8'd130, 7'd95,  16'sd370,   32'd30999}, ROW_QUIET, '0},
		'{'{8'd130, 7'd95,  16'sd370,   32'd31000}, ROW_ALERT,
			'{KIND_REMINDER, SEV_WARNING, 5'd2, 32'd2, 32'd31000, 8'd130, 7'd95, 16'sd370}},
		'{'{8'd45,  7'd80,  16'sd370,   32'd31001}, ROW_PREDICT, '0},
		'{'{8'd80,  7'd98,  16'sd370,   32'd31002}, ROW_QUIET, '0},
		'{'{8'd80,  7'd98,  16'sd370,   32'd31003}, ROW_QUIET, '0},
		'{'{8'd30,  7'd98,  16'sd370,   32'd31004}, ROW_QUIET, '0},
		'{'{8'd80,  7'd98,  16'sd370,   32'd31005}, ROW_QUIET, '0},
		'{'{8'd80,  7'd98,  16'sd370,   32'd31006}, ROW_QUIET, '0},
		'{'{8'd80,  7'd98,  16'sd370,   32'd31007}, ROW_ALERT,
			'{KIND_RECOVERED, SEV_NORMAL, 5'd0, 32'd3, 32'd31007, 8'd80, 7'd98, 16'sd370}},
		'{'{8'd80,  7'd98,  16'sd400,   32'hFFFF_FF00}, ROW_PREDICT, '0},
		'{'{8'd80,  7'd98,  16'sd400,   32'hFFFF_FF01}, ROW_PREDICT, '0},
		'{'{8'd80,  7'd98,  16'sd400,   32'hFFFF_FF02}, ROW_PREDICT, '0},
		'{'{8'd80,  7'd98,  16'sd400,   32'd29746}, ROW_PREDICT, '0},
		'{'{8'd50,  7'd90,  16'sd350,   32'd29747}, ROW_PREDICT, '0},
		'{'{8'd121, 7'd89,  16'sd380,   32'd29748}, ROW_PREDICT, '0},
		'{'{8'd40,  7'd85,  16'sd394,   32'd29749}, ROW_PREDICT, '0}
	};

	localparam cfg_t CrossedZeroCfg = '{16'h64C8, 7'd90, 16'sd400, 16'sd300,
		RstCriticalLimits, 8'd0, 8'd0, 32'd1000};
	localparam cfg_t AllOnesCfg = '{16'hFFFF, 7'h7F, 16'sh7FFF, 16'sh8000,
		{56{1'b1}}, 8'hFF, 8'hFF, 32'hFFFF_FFFF};

	logic                clk;
	logic                arst_n = 1'b0;
	logic                sample_valid = 1'b0;
	logic                sample_stall;
	sample_t             sample = '0;
	logic                alert_valid;
	logic                alert_stall = 1'b0;
	alert_t              alert;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [CfgIdxW-1:0]  cfg_index = '0;
	logic [CfgDataW-1:0] cfg_data = '0;

	cfg_t        regs = '{RstHrWarnLimits, RstSpo2WarnLow, RstTempWarnLow, RstTempWarnHigh,
		RstCriticalLimits, RstConfirmCount, RstClearCount, RstRepeatMs};
	logic        alarm_on = 1'b0;
	logic [7:0]  run_bad = '0;
	logic [7:0]  run_good = '0;
	logic [31:0] seq_next = RstNextSeq;
	logic [31:0] last_evt = '0;

	alert_t      due_alerts[$];
	int unsigned fail_count = 0;
	int unsigned send_idle_pct = 20;
	int unsigned take_idle_pct = 20;
	bit          hold_req = 1'b0;
	logic [31:0] now_ms = 32'd29750;

	vital_sign_alarm_qualifier dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.alert_valid  (alert_valid),
		.alert_stall  (alert_stall),
		.alert        (alert),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [ReasonW-1:0] reasons_of(input sample_t s);
		logic [ReasonW-1:0] r;
		r = '0;
		if (s.pulse_bpm < regs.hr_warn_limits[7:0])
			r[RsnHrLow] = 1'b1;
		else if (s.pulse_bpm > regs.hr_warn_limits[15:8])
			r[RsnHrHigh] = 1'b1;
		if (s.oxygen_saturation < regs.spo2_warn_low)
			r[RsnSpo2Low] = 1'b1;
		if ($signed(s.temperature) < $signed(regs.temp_warn_low))
			r[RsnTempLow] = 1'b1;
		else if ($signed(s.temperature) >= $signed(regs.temp_warn_high))
			r[RsnTempHigh] = 1'b1;
		return r;
	endfunction

	function automatic sev_t severity_of(input sample_t s, input logic [ReasonW-1:0] r);
		if (r == '0)
			return SEV_NORMAL;
		if (s.pulse_bpm < regs.critical_limits[7:0] ||
				s.pulse_bpm > regs.critical_limits[15:8] ||
				{1'b0, s.oxygen_saturation} < regs.critical_limits[23:16] ||
				$signed(s.temperature) < $signed(regs.critical_limits[39:24]) ||
				$signed(s.temperature) >= $signed(regs.critical_limits[55:40]))
			return SEV_CRITICAL;
		return SEV_WARNING;
	endfunction

	function automatic bit predict_alert(input sample_t s, output alert_t a);
		logic [ReasonW-1:0] r;
		logic [31:0]        since;
		bit                 fire;
		kind_t              k;
		r = reasons_of(s);
		since = s.timestamp_ms - last_evt;
		fire = 1'b0;
		k = KIND_TRIGGERED;
		a = '0;
		if (r != '0) begin
			run_good = '0;
			if (run_bad != RunMax)
				run_bad = run_bad + 8'd1;
			if (!alarm_on && run_bad >= regs.confirm_count) begin
				alarm_on = 1'b1;
				fire = 1'b1;
			end else if (alarm_on && since >= regs.repeat_interval_ms) begin
				fire = 1'b1;
				k = KIND_REMINDER;
			end
		end else begin
			run_bad = '0;
			if (run_good != RunMax)
				run_good = run_good + 8'd1;
			if (alarm_on && run_good >= regs.clear_count) begin
				alarm_on = 1'b0;
				fire = 1'b1;
				k = KIND_RECOVERED;
			end
		end
		if (fire) begin
			a.event_kind = k;
			a.severity = severity_of(s, r);
			a.reason_mask = r;
			a.sequence_number = seq_next;
			a.event_time_ms = s.timestamp_ms;
			a.event_pulse_bpm = s.pulse_bpm;
			a.event_oxygen = s.oxygen_saturation;
			a.event_temperature = s.temperature;
			seq_next = seq_next + 32'd1;
			last_evt = s.timestamp_ms;
		end
		return fire;
	endfunction

	function automatic sample_t pick_sample(input bit sick);
		sample_t s;
		int      lo;
		int      hi;
		s = '0;
		lo = regs.hr_warn_limits[7:0];
		hi = regs.hr_warn_limits[15:8];
		s.pulse_bpm = (lo <= hi) ? 8'($urandom_range(hi, lo)) : 8'($urandom);
		lo = regs.spo2_warn_low;
		s.oxygen_saturation = 7'($urandom_range(($urandom_range(0, 7) == 0) ? 127 : 100, lo));
		lo = $signed(regs.temp_warn_low);
		hi = $signed(regs.temp_warn_high);
		s.temperature = (lo < hi) ? 16'(lo + $urandom_range(hi - lo - 1, 0)) : 16'($urandom);
		if (sick) begin
			case ($urandom_range(0, 2))
				0: begin
					lo = regs.hr_warn_limits[7:0];
					hi = regs.hr_warn_limits[15:8];
					if (lo > 0 && (hi >= 255 || $urandom_range(0, 1) == 0))
						s.pulse_bpm = 8'($urandom_range(lo - 1, 0));
					else if (hi < 255)
						s.pulse_bpm = 8'($urandom_range(255, hi + 1));
				end
				1: begin
					lo = regs.spo2_warn_low;
					if (lo > 0)
						s.oxygen_saturation = 7'($urandom_range(lo - 1, 0));
				end
				default: begin
					if (lo > -32768 && (hi > 32767 - 1 || $urandom_range(0, 1) == 0))
						s.temperature = 16'(lo - 1 - int'($urandom_range(0,
							(lo + 32767 < 100) ? lo + 32767 : 100)));
					else
						s.temperature = 16'(hi + int'($urandom_range(0,
							(32767 - hi < 100) ? 32767 - hi : 100)));
				end
			endcase
		end
		return s;
	endfunction

	function automatic cfg_t roll_settings();
		cfg_t        c;
		logic [15:0] t_lo;
		logic [15:0] t_hi;
		c.hr_warn_limits = {8'($urandom_range(160, 100)), 8'($urandom_range(70, 30))};
		if ($urandom_range(0, 5) == 0)
			c.hr_warn_limits = 16'($urandom);
		c.spo2_warn_low = ($urandom_range(0, 7) == 0) ? 7'($urandom) : 7'($urandom_range(95, 80));
		c.temp_warn_low = 16'($urandom_range(365, 340));
		c.temp_warn_high = 16'($urandom_range(395, 370));
		if ($urandom_range(0, 7) == 0) begin
			c.temp_warn_low = 16'($urandom);
			c.temp_warn_high = 16'($urandom);
		end
		t_lo = 16'($urandom_range(350, 300));
		t_hi = 16'($urandom_range(420, 385));
		c.critical_limits = {t_hi, t_lo, 8'($urandom_range(90, 70)),
			8'($urandom_range(200, 130)), 8'($urandom_range(50, 20))};
		if ($urandom_range(0, 7) == 0)
			c.critical_limits = {24'($urandom), 32'($urandom)};
		c.confirm_count = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(5, 0));
		c.clear_count = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(5, 0));
		c.repeat_interval_ms = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(5000, 0);
		return c;
	endfunction

	task automatic send_sample(input sample_t s, input row_mode_t how, input alert_t typed);
		alert_t a;
		bit     fire;
		if ($urandom_range(0, 99) < send_idle_pct) begin
			sample_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample <= s;
		do @(posedge clk); while (sample_stall);
		fire = predict_alert(s, a);
		if (how == ROW_PREDICT && fire)
			due_alerts.push_back(a);
		else if (how == ROW_ALERT)
			due_alerts.push_back(typed);
	endtask

	task automatic settle();
		sample_valid <= 1'b0;
		while (due_alerts.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CfgDataW-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_HR_WARN:   regs.hr_warn_limits = data[15:0];
			CFG_SPO2_WARN: regs.spo2_warn_low = data[6:0];
			CFG_TEMP_LOW:  regs.temp_warn_low = data[15:0];
			CFG_TEMP_HIGH: regs.temp_warn_high = data[15:0];
			CFG_CRITICAL:  regs.critical_limits = data[55:0];
			CFG_CONFIRM:   regs.confirm_count = data[7:0];
			CFG_CLEAR:     regs.clear_count = data[7:0];
			CFG_REPEAT:    regs.repeat_interval_ms = data[31:0];
			default: ;
		endcase
	endtask

	task automatic load_settings(input cfg_t c);
		write_reg(CFG_HR_WARN, c.hr_warn_limits);
		write_reg(CFG_SPO2_WARN, c.spo2_warn_low);
		write_reg(CFG_TEMP_LOW, c.temp_warn_low);
		write_reg(CFG_TEMP_HIGH, c.temp_warn_high);
		write_reg(CFG_CRITICAL, c.critical_limits);
		write_reg(CFG_CONFIRM, c.confirm_count);
		write_reg(CFG_CLEAR, c.clear_count);
		write_reg(CFG_REPEAT, c.repeat_interval_ms);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(input cfg_t c, input int unsigned items,
			input int unsigned send_pct, input int unsigned take_pct, input bit squeeze);
		bit          sick;
		int unsigned left;
		sample_t     s;
		load_settings(c);
		send_idle_pct = send_pct;
		take_idle_pct = take_pct;
		hold_req = squeeze;
		sick = 1'b0;
		left = 0;
		repeat (items) begin
			if (left == 0) begin
				sick = ~sick;
				left = $urandom_range(1, (sick ? regs.confirm_count : regs.clear_count) + 2);
			end
			left--;
			if ($urandom_range(0, 7) == 0) begin
				s.pulse_bpm = 8'($urandom);
				s.oxygen_saturation = 7'($urandom);
				s.temperature = 16'($urandom);
			end else
				s = pick_sample(sick);
			if ($urandom_range(0, 39) == 0)
				now_ms = $urandom;
			else
				now_ms = now_ms + $urandom_range(3000, 0);
			s.timestamp_ms = now_ms;
			send_sample(s, ROW_PREDICT, '0);
		end
		settle();
	endtask

	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				alert_stall <= 1'b1;
				repeat (LongHold) @(posedge clk);
			end else if ($urandom_range(0, 99) < take_idle_pct) begin
				alert_stall <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end else
				alert_stall <= 1'b0;
		end
	end

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin : take_alert
		alert_t want;
		if (arst_n && alert_valid && !alert_stall) begin
			if (due_alerts.size() == 0) begin
				$error("alert with nothing pending: sequence_number %0h", alert.sequence_number);
				fail_count++;
			end else begin
				want = due_alerts.pop_front();
				check_field("event_kind", want.event_kind, alert.event_kind);
				check_field("severity", want.severity, alert.severity);
				check_field("reason_mask", want.reason_mask, alert.reason_mask);
				check_field("sequence_number", want.sequence_number, alert.sequence_number);
				check_field("event_time_ms", want.event_time_ms, alert.event_time_ms);
				check_field("event_pulse_bpm", want.event_pulse_bpm, alert.event_pulse_bpm);
				check_field("event_oxygen", want.event_oxygen, alert.event_oxygen);
				check_field("event_temperature", want.event_temperature,
					alert.event_temperature);
			end
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < $size(Plan); i++)
			send_sample(Plan[i].s, Plan[i].how, Plan[i].want);
		settle();
		run_phase(CrossedZeroCfg, 60, 15, 15, 1'b0);
		run_phase('0, 80, 10, 25, 1'b1);
		run_phase(AllOnesCfg, 300, 5, 5, 1'b0);
		repeat (4)
			run_phase(roll_settings(), 60, 10 * $urandom_range(0, 3), 10 * $urandom_range(0, 3),
				1'b0);
		run_phase(roll_settings(), 60, 0, 0, 1'b0);
		repeat (DrainCycles) @(posedge clk);
		if (fail_count == 0)
			$display("vital_sign_alarm_qualifier verification clean");
		else
			$display("vital_sign_alarm_qualifier verification failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("vital_sign_alarm_qualifier verification failed");
		$finish;
	end

endmodule
`default_nettype wire

/* vital_sign_alarm_qualifier.f */
rtl/core/vsaq_pkg.sv
rtl/core/vsaq_cfg.sv
rtl/core/vsaq_classify.sv
rtl/core/vsaq_tracker.sv
rtl/core/vital_sign_alarm_qualifier.sv
sim/vital_sign_alarm_qualifier_tb.sv
